// File: src/dsmt_pkg.sv
// Shared types and codes for the dual stack with minimum tracking.
// Used by dsmt_lane and by the top level dual_stack_with_min_tracking.
`timescale 1ns / 1ps

package dsmt_pkg;

    localparam logic OP_PUSH    = 1'b0;
    localparam logic OP_POP     = 1'b1;

    localparam logic SEL_FIRST  = 1'b0;
    localparam logic SEL_SECOND = 1'b1;

    localparam logic MODE_SPLIT = 1'b0;
    localparam logic MODE_MIN   = 1'b1;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_OVERFLOW  = 2'd1,
        STATUS_UNDERFLOW = 2'd2
    } status_t;

    // Command to one stack for the current transfer; push and pop never both set.
    typedef struct packed {
        logic push;
        logic pop;
    } lane_cmd_t;

endpackage

// File: src/dsmt_stack_mem.sv
// Simple one-write, one-read memory with a registered read port.
// Holds the deep entries of one stack; no dependencies.
`timescale 1ns / 1ps

module dsmt_stack_mem #(
    parameter int DW    = 32,
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [DW-1:0] wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [DW-1:0] rd_data
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: src/dsmt_lane.sv
// One LIFO stack with its top two entries held in registers and the rest in memory.
// Depends on dsmt_pkg and dsmt_stack_mem.
`timescale 1ns / 1ps

module dsmt_lane
    import dsmt_pkg::*;
#(
    parameter int DW    = 32,
    parameter int DEPTH = 64,
    parameter int AW    = 6,
    parameter int CW    = 7
) (
    input  logic          clk,
    input  logic          rst_n,
    input  lane_cmd_t     cmd,
    input  logic [DW-1:0] din,
    output logic [CW-1:0] count,
    output logic [DW-1:0] top,
    output logic [CW-1:0] count_after,
    output logic [DW-1:0] top_after
);

    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic [DW-1:0] top_reg;
    logic [DW-1:0] sub_reg;
    logic          sub_mem_reg;
    logic [DW-1:0] rd_data;
    logic [DW-1:0] sub_eff;
    logic          rd_en;
    logic [CW-1:0] rd_index;

    // After a pop the entry below the top comes from the memory read register.
    assign sub_eff  = sub_mem_reg ? rd_data : sub_reg;
    assign rd_index = count_reg - CW'(3);
    assign rd_en    = cmd.pop && (count_reg >= CW'(3));

    dsmt_stack_mem #(
        .DW    (DW),
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .clk     (clk),
        .wr_en   (cmd.push),
        .wr_addr (count_reg[AW-1:0]),
        .wr_data (din),
        .rd_en   (rd_en),
        .rd_addr (rd_index[AW-1:0]),
        .rd_data (rd_data)
    );

    always_comb
    begin
        count_next = count_reg;
        top_after  = top_reg;
        if (cmd.push)
        begin
            count_next = count_reg + CW'(1);
            top_after  = din;
        end
        else if (cmd.pop)
        begin
            count_next = count_reg - CW'(1);
            top_after  = sub_eff;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            sub_mem_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (cmd.push)
            begin
                sub_mem_reg <= 1'b0;
            end
            else if (cmd.pop)
            begin
                sub_mem_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            top_reg <= din;
            sub_reg <= top_reg;
        end
        else if (cmd.pop)
        begin
            top_reg <= sub_eff;
        end
    end

    assign count       = count_reg;
    assign top         = top_reg;
    assign count_after = count_next;

endmodule

// File: src/dual_stack_with_min_tracking.sv
// Top level of the dual stack with minimum tracking.
// Depends on dsmt_pkg and dsmt_lane (which holds dsmt_stack_mem).
`timescale 1ns / 1ps

// Two LIFO stacks share DEPTH slots: the first counts up from the bottom, the
// second down from the top, and the store is full when the counts sum to DEPTH.
// Each stack is kept as its own bank with its top two entries in registers,
// so any sequence of operations runs at full rate while the receiver keeps up.
//
// Input channel s_axis: one transfer is one operation. tuser carries the opcode
// (0 push, 1 pop) and the stack select; tdata carries the signed value.
// Output channel m_axis: exactly one result transfer per operation, in order.
// The cfg_wr_en / cfg_wr_data port writes the mode bit (0 two stacks, 1 min stack);
// the user writes it only while no operation is in flight; the block does not enforce it.
//
// A result passes the input register and then the result register: the operation
// waits in the input register, and the state update and the result register load
// share the edge at which it advances. Throughput is one operation per cycle while
// the receiver keeps up, set by the registered update of the cached tops and counts.
// When the receiver stalls, the result register holds and the input register
// fills; s_axis_tready drops only when both are occupied.
// Reset empties both stacks and selects mode 0; stack memory is not cleared,
// since only entries below the counts are ever read.
module dual_stack_with_min_tracking
    import dsmt_pkg::*;
#(
    parameter int DEPTH      = 64,
    parameter int DATA_WIDTH = 32
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_wr_en,
    input  logic         cfg_wr_data,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // Fields from bit 0: value[31:0].
    input  logic [31:0]  s_axis_tdata,
    // Fields from bit 0: opcode[0], stack_sel[1].
    input  logic [1:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // Fields from bit 0: popped_value[31:0], status[33:32], top_first[65:34],
    // top_second[97:66], empty_first[98], empty_second[99], full_flag[100],
    // zero fill[103:101].
    output logic [103:0] m_axis_tdata
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW:0] DEPTH_W     = (CW + 1)'(DEPTH);
    localparam logic [CW:0] DEPTH_M1_W  = (CW + 1)'(DEPTH - 1);

    // Configuration.
    logic mode_reg;

    // Input register.
    logic                  in_valid_reg;
    logic                  in_op_reg;
    logic                  in_sel_reg;
    logic [DATA_WIDTH-1:0] in_val_reg;

    // Result register.
    logic        out_valid_reg;
    logic [31:0] popped_reg;
    status_t     status_reg;
    logic [31:0] top_first_reg;
    logic [31:0] top_second_reg;
    logic        empty_first_reg;
    logic        empty_second_reg;
    logic        full_reg;

    logic advance;

    lane_cmd_t             cmd1;
    lane_cmd_t             cmd2;
    logic [CW-1:0]         c1;
    logic [CW-1:0]         c2;
    logic [CW-1:0]         c1_after;
    logic [CW-1:0]         c2_after;
    logic [DATA_WIDTH-1:0] top1;
    logic [DATA_WIDTH-1:0] top2;
    logic [DATA_WIDTH-1:0] top1_after;
    logic [DATA_WIDTH-1:0] top2_after;
    logic [CW:0]           used;
    logic [CW:0]           used_after;
    logic                  is_full;
    logic                  near_full;
    logic                  both;
    status_t               status_next;
    logic [DATA_WIDTH-1:0] popped_next;

    // The operation in the input register completes whenever the result
    // register is free or being emptied in this cycle.
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    assign used      = (CW + 1)'(c1) + (CW + 1)'(c2);
    assign is_full   = (used == DEPTH_W);
    assign near_full = (used >= DEPTH_M1_W);
    // In min mode the value also lands on the minimum stack when it ties or
    // beats the current minimum, or when that stack is empty.
    assign both      = (c2 == '0) || ($signed(in_val_reg) <= $signed(top2));

    always_comb
    begin
        cmd1        = '0;
        cmd2        = '0;
        status_next = STATUS_OK;
        popped_next = '0;
        if (in_op_reg == OP_PUSH)
        begin
            if (mode_reg == MODE_SPLIT)
            begin
                if (is_full)
                begin
                    status_next = STATUS_OVERFLOW;
                end
                else if (in_sel_reg == SEL_FIRST)
                begin
                    cmd1.push = 1'b1;
                end
                else
                begin
                    cmd2.push = 1'b1;
                end
            end
            else
            begin
                if (both ? near_full : is_full)
                begin
                    status_next = STATUS_OVERFLOW;
                end
                else
                begin
                    cmd1.push = 1'b1;
                    cmd2.push = both;
                end
            end
        end
        else
        begin
            if ((mode_reg == MODE_SPLIT) && (in_sel_reg == SEL_SECOND))
            begin
                if (c2 == '0)
                begin
                    status_next = STATUS_UNDERFLOW;
                end
                else
                begin
                    cmd2.pop    = 1'b1;
                    popped_next = top2;
                end
            end
            else
            begin
                if (c1 == '0)
                begin
                    status_next = STATUS_UNDERFLOW;
                end
                else
                begin
                    cmd1.pop    = 1'b1;
                    popped_next = top1;
                    // The minimum leaves with the element that set it. After a
                    // mode switch the minimum stack may be empty, and this pop leaves it empty.
                    cmd2.pop    = (mode_reg == MODE_MIN) && (c2 != '0) && (top1 == top2);
                end
            end
        end
        if (!advance)
        begin
            cmd1 = '0;
            cmd2 = '0;
        end
    end

    dsmt_lane #(
        .DW    (DATA_WIDTH),
        .DEPTH (DEPTH),
        .AW    (AW),
        .CW    (CW)
    ) u_first (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd1),
        .din         (in_val_reg),
        .count       (c1),
        .top         (top1),
        .count_after (c1_after),
        .top_after   (top1_after)
    );

    dsmt_lane #(
        .DW    (DATA_WIDTH),
        .DEPTH (DEPTH),
        .AW    (AW),
        .CW    (CW)
    ) u_second (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd2),
        .din         (in_val_reg),
        .count       (c2),
        .top         (top2),
        .count_after (c2_after),
        .top_after   (top2_after)
    );

    assign used_after = (CW + 1)'(c1_after) + (CW + 1)'(c2_after);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_SPLIT;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                mode_reg <= cfg_wr_data;
            end
            if (s_axis_tready)
            begin
                in_valid_reg <= s_axis_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_op_reg  <= s_axis_tuser[0];
            in_sel_reg <= s_axis_tuser[1];
            in_val_reg <= DATA_WIDTH'($signed(s_axis_tdata));
        end
        if (advance)
        begin
            popped_reg       <= 32'($signed(popped_next));
            status_reg       <= status_next;
            top_first_reg    <= (c1_after == '0) ? '0 : 32'($signed(top1_after));
            top_second_reg   <= (c2_after == '0) ? '0 : 32'($signed(top2_after));
            empty_first_reg  <= (c1_after == '0);
            empty_second_reg <= (c2_after == '0);
            full_reg         <= (used_after == DEPTH_W);
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {3'b000, full_reg, empty_second_reg, empty_first_reg,
                            top_second_reg, top_first_reg, status_reg, popped_reg};

endmodule

// File: tb/tb_top.sv
// Self-checking testbench for dual_stack_with_min_tracking.
// Needs dsmt_pkg and the RTL; drives directed and random push/pop traffic and compares
// every result transfer against a behavioral predictor of the two stacks or a typed-in result.
`timescale 1ns / 1ps

module tb_top
    import dsmt_pkg::*;
();

    localparam int DEPTH        = 64;
    localparam int DATA_WIDTH   = 32;
    localparam int RANDOM_ITEMS = 1300;
    localparam int N_ROWS       = 25;

    // One result transfer, laid out exactly as m_axis_tdata (MSB first here).
    typedef struct packed {
        logic [2:0]  fill;
        logic        full_flag;
        logic        empty_second;
        logic        empty_first;
        logic [31:0] top_second;
        logic [31:0] top_first;
        status_t     status;
        logic [31:0] popped_value;
    } stack_result_t;

    // One row of the directed table. When has_want is set, want is the result
    // typed in by hand; otherwise the predictor supplies the expectation.
    typedef struct {
        logic          mode;
        logic          opcode;
        logic          stack_sel;
        logic [31:0]   value;
        bit            has_want;
        stack_result_t want;
    } op_row_t;

    logic         clk;
    logic         rst_n;
    logic         cfg_wr_en;
    logic         cfg_wr_data;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [31:0]  s_axis_tdata;
    logic [1:0]   s_axis_tuser;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [103:0] m_axis_tdata;

    // Predictor state: the shared slot array, both stack heights and the mode bit.
    logic [31:0]  slot_mem [DEPTH];
    int           low_count;
    int           high_count;
    logic         cur_mode;

    stack_result_t expected_results [$];
    int            mismatch_count;
    int            burst_left;
    bit            gaps_on;
    op_row_t       directed_rows [N_ROWS];

    dual_stack_with_min_tracking #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // The run is bounded no matter what the block does.
    initial
    begin
        #5000000;
        $display("FAILURE");
        $finish;
    end

    function automatic logic [31:0] low_top();
        return (low_count == 0) ? 32'd0 : slot_mem[low_count - 1];
    endfunction

    function automatic logic [31:0] high_top();
        return (high_count == 0) ? 32'd0 : slot_mem[DEPTH - high_count];
    endfunction

    function automatic stack_result_t build_result(logic [31:0] popped, status_t st,
                                                   logic [31:0] t1, logic [31:0] t2,
                                                   logic e1, logic e2, logic full);
        stack_result_t r;
        r              = '0;
        r.popped_value = popped;
        r.status       = st;
        r.top_first    = t1;
        r.top_second   = t2;
        r.empty_first  = e1;
        r.empty_second = e2;
        r.full_flag    = full;
        return r;
    endfunction

    // Applies one operation to the predictor state and returns the result it yields.
    // A refused operation leaves every count and slot untouched.
    function automatic stack_result_t predict_stack_op(logic op, logic sel, logic [31:0] value);
        logic [31:0] popped;
        status_t     st;
        bit          both;
        int          free_n;
        popped = '0;
        st     = STATUS_OK;
        free_n = DEPTH - low_count - high_count;
        if (op == OP_PUSH)
        begin
            if (cur_mode == MODE_SPLIT)
            begin
                if (free_n == 0)
                    st = STATUS_OVERFLOW;
                else if (sel == SEL_FIRST)
                begin
                    slot_mem[low_count] = value;
                    low_count++;
                end
                else
                begin
                    high_count++;
                    slot_mem[DEPTH - high_count] = value;
                end
            end
            else
            begin
                // A new minimum (or a tie) goes onto both stacks and needs two slots.
                both = (high_count == 0) || ($signed(value) <= $signed(high_top()));
                if (free_n < (both ? 2 : 1))
                    st = STATUS_OVERFLOW;
                else
                begin
                    slot_mem[low_count] = value;
                    low_count++;
                    if (both)
                    begin
                        high_count++;
                        slot_mem[DEPTH - high_count] = value;
                    end
                end
            end
        end
        else if (cur_mode == MODE_SPLIT && sel == SEL_SECOND)
        begin
            if (high_count == 0)
                st = STATUS_UNDERFLOW;
            else
            begin
                popped = high_top();
                high_count--;
            end
        end
        else
        begin
            if (low_count == 0)
                st = STATUS_UNDERFLOW;
            else
            begin
                popped = low_top();
                low_count--;
                // The minimum leaves only when the popped element equals it.
                if (cur_mode == MODE_MIN && high_count != 0 && popped == high_top())
                    high_count--;
            end
        end
        return build_result(popped, st, low_top(), high_top(), low_count == 0,
                            high_count == 0, (low_count + high_count) == DEPTH);
    endfunction

    function automatic op_row_t table_row(logic mode, logic op, logic sel, logic [31:0] value,
                                          bit has_want, stack_result_t want);
        op_row_t r;
        r.mode      = mode;
        r.opcode    = op;
        r.stack_sel = sel;
        r.value     = value;
        r.has_want  = has_want;
        r.want      = want;
        return r;
    endfunction

    // Value mix: full random, a narrow band that makes ties common, or extremes.
    function automatic logic [31:0] pick_value(int style);
        if (style == 0)
            return $urandom;
        if (style == 1)
            return $urandom_range(0, 6) - 3;
        case ($urandom_range(0, 4))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'h0000_0000;
            3: return 32'hffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    task automatic idle_cycles(int n);
        repeat (n)
        begin
            @(negedge clk);
            s_axis_tvalid = 1'b0;
            s_axis_tdata  = $urandom;
            s_axis_tuser  = 2'($urandom);
        end
    endtask

    // Offers one operation and returns once its transfer has been accepted.
    // The sender works in bursts; between bursts it may leave a random gap.
    task automatic issue_op(logic op, logic sel, logic [31:0] value, bit has_want,
                            stack_result_t want);
        stack_result_t predicted;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            if (gaps_on)
                idle_cycles($urandom_range(1, 8));
        end
        burst_left--;
        predicted = predict_stack_op(op, sel, value);
        expected_results.push_back(has_want ? want : predicted);
        @(negedge clk);
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = {sel, op};
        s_axis_tdata  = value;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    // The mode bit is only written while nothing is in flight.
    task automatic set_mode(logic m);
        @(negedge clk);
        s_axis_tvalid = 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        @(negedge clk);
        cfg_wr_en   = 1'b1;
        cfg_wr_data = m;
        @(negedge clk);
        cfg_wr_en   = 1'b0;
        cur_mode    = m;
    endtask

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            mismatch_count++;
            $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
        end
    endtask

    // Result checker: every accepted result transfer is compared with the oldest
    // expectation, field by field.
    always @(posedge clk)
    begin : result_check
        stack_result_t got;
        stack_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = m_axis_tdata;
            if (expected_results.size() == 0)
            begin
                mismatch_count++;
                $display("%0t: result transfer with none expected: expected none, actual %h",
                         $time, m_axis_tdata);
            end
            else
            begin
                want = expected_results.pop_front();
                check_field("popped_value", want.popped_value, got.popped_value);
                check_field("status",       32'(want.status),       32'(got.status));
                check_field("top_first",    want.top_first,    got.top_first);
                check_field("top_second",   want.top_second,   got.top_second);
                check_field("empty_first",  32'(want.empty_first),  32'(got.empty_first));
                check_field("empty_second", 32'(want.empty_second), 32'(got.empty_second));
                check_field("full_flag",    32'(want.full_flag),    32'(got.full_flag));
                check_field("zero fill",    32'(want.fill),         32'(got.fill));
            end
        end
    end

    // Receiver: a pattern of its own, in stretches of always ready, random and
    // periodic stalls. Now and then it holds off for a long stretch so that the
    // block fills up and has to stall its input.
    initial
    begin : result_sink
        int seg;
        int span;
        int kind;
        m_axis_tready = 1'b0;
        seg = 0;
        forever
        begin
            seg++;
            if (seg == 4 || $urandom_range(0, 29) == 0)
            begin
                repeat (150)
                begin
                    @(negedge clk);
                    m_axis_tready = 1'b0;
                end
            end
            else
            begin
                kind = $urandom_range(0, 3);
                span = $urandom_range(10, 150);
                for (int i = 0; i < span; i++)
                begin
                    @(negedge clk);
                    case (kind)
                        0: m_axis_tready = 1'b1;
                        1: m_axis_tready = 1'($urandom_range(0, 1));
                        2: m_axis_tready = (i % 3) != 0;
                        default: m_axis_tready = $urandom_range(0, 4) != 0;
                    endcase
                end
            end
        end
    end

    // Main sequence: reset, the directed table, then random segments.
    initial
    begin : stimulus
        stack_result_t empty_underflow;
        int            items;
        int            seg;
        int            seg_len;
        int            push_pct;
        int            style;
        logic          seg_mode;
        logic          op;

        rst_n          = 1'b0;
        cfg_wr_en      = 1'b0;
        cfg_wr_data    = 1'b0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        s_axis_tuser   = '0;
        low_count      = 0;
        high_count     = 0;
        cur_mode       = MODE_SPLIT;
        mismatch_count = 0;
        burst_left     = 0;
        gaps_on        = 1'b1;

        empty_underflow = build_result(32'd0, STATUS_UNDERFLOW, 32'd0, 32'd0, 1'b1, 1'b1, 1'b0);

        // Two stacks: pops on empty, extreme values on both sides, then drain.
        directed_rows[0]  = table_row(MODE_SPLIT, OP_POP, SEL_FIRST, 32'h0, 1'b1,
                                      empty_underflow);
        directed_rows[1]  = table_row(MODE_SPLIT, OP_POP, SEL_SECOND, 32'hffff_ffff, 1'b1,
                                      empty_underflow);
        directed_rows[2]  = table_row(MODE_SPLIT, OP_PUSH, SEL_FIRST, 32'h7fff_ffff, 1'b1,
                                      build_result(32'd0, STATUS_OK, 32'h7fff_ffff, 32'd0,
                                                   1'b0, 1'b1, 1'b0));
        directed_rows[3]  = table_row(MODE_SPLIT, OP_PUSH, SEL_SECOND, 32'h8000_0000, 1'b1,
                                      build_result(32'd0, STATUS_OK, 32'h7fff_ffff,
                                                   32'h8000_0000, 1'b0, 1'b0, 1'b0));
        directed_rows[4]  = table_row(MODE_SPLIT, OP_PUSH, SEL_FIRST, 32'h0, 1'b0, '0);
        directed_rows[5]  = table_row(MODE_SPLIT, OP_PUSH, SEL_SECOND, 32'hffff_ffff, 1'b0, '0);
        directed_rows[6]  = table_row(MODE_SPLIT, OP_POP, SEL_FIRST, 32'h1234_5678, 1'b0, '0);
        directed_rows[7]  = table_row(MODE_SPLIT, OP_POP, SEL_SECOND, 32'h0, 1'b0, '0);
        directed_rows[8]  = table_row(MODE_SPLIT, OP_POP, SEL_FIRST, 32'hffff_ffff, 1'b0, '0);
        directed_rows[9]  = table_row(MODE_SPLIT, OP_POP, SEL_SECOND, 32'h0, 1'b0, '0);
        // Leave elements on the first stack only, then switch to min mode, so the
        // first pop there finds the minimum stack empty.
        directed_rows[10] = table_row(MODE_SPLIT, OP_PUSH, SEL_FIRST, 32'd5, 1'b0, '0);
        directed_rows[11] = table_row(MODE_SPLIT, OP_PUSH, SEL_FIRST, 32'd3, 1'b0, '0);
        directed_rows[12] = table_row(MODE_MIN, OP_POP, SEL_SECOND, 32'h0, 1'b0, '0);
        // Min mode: a first push, a larger one, a tie, a new minimum, a maximum;
        // stack_sel is varied to show that it is ignored.
        directed_rows[13] = table_row(MODE_MIN, OP_PUSH, SEL_FIRST, 32'd10, 1'b0, '0);
        directed_rows[14] = table_row(MODE_MIN, OP_PUSH, SEL_SECOND, 32'd20, 1'b0, '0);
        directed_rows[15] = table_row(MODE_MIN, OP_PUSH, SEL_FIRST, 32'd10, 1'b0, '0);
        directed_rows[16] = table_row(MODE_MIN, OP_PUSH, SEL_SECOND, 32'h8000_0000, 1'b0, '0);
        directed_rows[17] = table_row(MODE_MIN, OP_PUSH, SEL_FIRST, 32'h7fff_ffff, 1'b0, '0);
        directed_rows[18] = table_row(MODE_MIN, OP_POP, SEL_SECOND, 32'h0, 1'b0, '0);
        directed_rows[19] = table_row(MODE_MIN, OP_POP, SEL_FIRST, 32'h0, 1'b0, '0);
        directed_rows[20] = table_row(MODE_MIN, OP_POP, SEL_SECOND, 32'hffff_ffff, 1'b0, '0);
        directed_rows[21] = table_row(MODE_MIN, OP_POP, SEL_FIRST, 32'h0, 1'b0, '0);
        directed_rows[22] = table_row(MODE_MIN, OP_POP, SEL_SECOND, 32'h0, 1'b0, '0);
        directed_rows[23] = table_row(MODE_MIN, OP_POP, SEL_FIRST, 32'h0, 1'b0, '0);
        directed_rows[24] = table_row(MODE_MIN, OP_POP, SEL_FIRST, 32'h0, 1'b1,
                                      empty_underflow);

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (int i = 0; i < N_ROWS; i++)
        begin
            if (directed_rows[i].mode != cur_mode)
                set_mode(directed_rows[i].mode);
            issue_op(directed_rows[i].opcode, directed_rows[i].stack_sel,
                     directed_rows[i].value, directed_rows[i].has_want, directed_rows[i].want);
        end

        // Random segments. The first four are steered: fill the split store until
        // pushes are refused, push hard in min mode on a nearly full store, then
        // drain in both modes. Later segments pick mode and push rate at random.
        items = 0;
        seg   = 0;
        while (items < RANDOM_ITEMS)
        begin
            case (seg)
                0:
                begin
                    seg_mode = MODE_SPLIT;
                    push_pct = 95;
                end
                1:
                begin
                    seg_mode = MODE_MIN;
                    push_pct = 85;
                end
                2:
                begin
                    seg_mode = MODE_MIN;
                    push_pct = 10;
                end
                3:
                begin
                    seg_mode = MODE_SPLIT;
                    push_pct = 10;
                end
                default:
                begin
                    seg_mode = ($urandom_range(0, 2) == 0) ? ~cur_mode : cur_mode;
                    case ($urandom_range(0, 4))
                        0: push_pct = 5;
                        1: push_pct = 30;
                        2: push_pct = 50;
                        3: push_pct = 70;
                        default: push_pct = 95;
                    endcase
                end
            endcase
            if (seg_mode != cur_mode)
                set_mode(seg_mode);
            seg_len = $urandom_range(40, 120);
            style   = $urandom_range(0, 2);
            gaps_on = $urandom_range(0, 3) != 0;
            repeat (seg_len)
            begin
                op = ($urandom_range(0, 99) < push_pct) ? OP_PUSH : OP_POP;
                issue_op(op, 1'($urandom_range(0, 1)), pick_value(style), 1'b0, '0);
                items++;
            end
            seg++;
        end

        @(negedge clk);
        s_axis_tvalid = 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        // Keep running so that a stray extra result would still be seen.
        repeat (10) @(posedge clk);
        if (mismatch_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
